### rtl/dev_pkg.sv
`default_nettype none

package dev_pkg;

  localparam int FracBits = 16;
  localparam int WordW    = 32;
  localparam int GainW    = 17;
  localparam int TpsW     = 20;
  localparam int DiffW    = WordW + 1;
  localparam int MulW     = TpsW + 1;
  localparam int ProdW    = MulW + DiffW;
  localparam int AdjW     = ProdW - FracBits;
  localparam int SumW     = ((AdjW > WordW) ? AdjW : WordW) + 1;
  localparam int DivW     = ProdW - 1;
  localparam int CntW     = $clog2(DivW);
  localparam int PcW      = 5;
  localparam int PaddrW   = 4;
  localparam int PdataW   = 32;

  localparam logic [GainW-1:0] GainOne  = GainW'(64'd1 << FracBits);
  localparam logic [TpsW-1:0]  TpsReset = TpsW'(1000);

  localparam logic signed [WordW-1:0] WordMax = {1'b0, {(WordW-1){1'b1}}};
  localparam logic signed [WordW-1:0] WordMin = {1'b1, {(WordW-1){1'b0}}};

  typedef enum logic [1:0] {
    REG_DEPTH_GAIN       = 2'd0,
    REG_VELOCITY_GAIN    = 2'd1,
    REG_TICKS_PER_SECOND = 2'd2
  } dev_reg_e;

  typedef struct packed {
    logic [GainW-1:0] depth_gain;
    logic [GainW-1:0] velocity_gain;
    logic [TpsW-1:0]  ticks_per_second;
  } dev_cfg_t;

  typedef enum logic [4:0] {
    OP_NOP      = 5'd0,
    OP_LATCH    = 5'd1,
    OP_DT       = 5'd2,
    OP_DIFF_D   = 5'd3,
    OP_MUL_D    = 5'd4,
    OP_ADD_D    = 5'd5,
    OP_DZ       = 5'd6,
    OP_MUL_T    = 5'd7,
    OP_DIV_INIT = 5'd8,
    OP_DIV_STEP = 5'd9,
    OP_QSAT     = 5'd10,
    OP_DIFF_V   = 5'd11,
    OP_MUL_V    = 5'd12,
    OP_ADD_V    = 5'd13,
    OP_FIRST_V  = 5'd14,
    OP_IGNORE   = 5'd15,
    OP_FIRST    = 5'd16,
    OP_EMIT     = 5'd17
  } dev_op_e;

  typedef enum logic [2:0] {
    COND_NEVER       = 3'd0,
    COND_ALWAYS      = 3'd1,
    COND_NO_IN       = 3'd2,
    COND_NOT_STARTED = 3'd3,
    COND_TICK_SAME   = 3'd4,
    COND_DIV_MORE    = 3'd5,
    COND_VEL_NEW     = 3'd6,
    COND_OUT_FREE    = 3'd7
  } dev_cond_e;

  typedef struct packed {
    dev_op_e          op;
    dev_cond_e        cond;
    logic [PcW-1:0]   target;
  } dev_ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic started;
    logic vel_started;
    logic tick_same;
    logic div_more;
    logic out_free;
  } dev_stat_t;

  localparam logic [PcW-1:0] StWait    = 5'd0;
  localparam logic [PcW-1:0] StCheck   = 5'd1;
  localparam logic [PcW-1:0] StDt      = 5'd2;
  localparam logic [PcW-1:0] StDiffD   = 5'd3;
  localparam logic [PcW-1:0] StMulD    = 5'd4;
  localparam logic [PcW-1:0] StAddD    = 5'd5;
  localparam logic [PcW-1:0] StDz      = 5'd6;
  localparam logic [PcW-1:0] StMulT    = 5'd7;
  localparam logic [PcW-1:0] StDivInit = 5'd8;
  localparam logic [PcW-1:0] StDivStep = 5'd9;
  localparam logic [PcW-1:0] StQsat    = 5'd10;
  localparam logic [PcW-1:0] StDiffV   = 5'd11;
  localparam logic [PcW-1:0] StMulV    = 5'd12;
  localparam logic [PcW-1:0] StAddV    = 5'd13;
  localparam logic [PcW-1:0] StFirstV  = 5'd14;
  localparam logic [PcW-1:0] StIgnore  = 5'd15;
  localparam logic [PcW-1:0] StFirst   = 5'd16;
  localparam logic [PcW-1:0] StEmit    = 5'd17;
  localparam logic [PcW-1:0] StRetry   = 5'd18;

  function automatic dev_ctrl_t dev_ucode(input logic [PcW-1:0] pc);
    dev_ctrl_t w;
    w = '{op: OP_NOP, cond: COND_ALWAYS, target: StWait};
    case (pc)
      StWait:    w = '{op: OP_LATCH,    cond: COND_NO_IN,       target: StWait};
      StCheck:   w = '{op: OP_NOP,      cond: COND_NOT_STARTED, target: StFirst};
      StDt:      w = '{op: OP_DT,       cond: COND_TICK_SAME,   target: StIgnore};
      StDiffD:   w = '{op: OP_DIFF_D,   cond: COND_NEVER,       target: StWait};
      StMulD:    w = '{op: OP_MUL_D,    cond: COND_NEVER,       target: StWait};
      StAddD:    w = '{op: OP_ADD_D,    cond: COND_NEVER,       target: StWait};
      StDz:      w = '{op: OP_DZ,       cond: COND_NEVER,       target: StWait};
      StMulT:    w = '{op: OP_MUL_T,    cond: COND_NEVER,       target: StWait};
      StDivInit: w = '{op: OP_DIV_INIT, cond: COND_NEVER,       target: StWait};
      StDivStep: w = '{op: OP_DIV_STEP, cond: COND_DIV_MORE,    target: StDivStep};
      StQsat:    w = '{op: OP_QSAT,     cond: COND_VEL_NEW,     target: StFirstV};
      StDiffV:   w = '{op: OP_DIFF_V,   cond: COND_NEVER,       target: StWait};
      StMulV:    w = '{op: OP_MUL_V,    cond: COND_NEVER,       target: StWait};
      StAddV:    w = '{op: OP_ADD_V,    cond: COND_ALWAYS,      target: StEmit};
      StFirstV:  w = '{op: OP_FIRST_V,  cond: COND_ALWAYS,      target: StEmit};
      StIgnore:  w = '{op: OP_IGNORE,   cond: COND_ALWAYS,      target: StEmit};
      StFirst:   w = '{op: OP_FIRST,    cond: COND_NEVER,       target: StWait};
      StEmit:    w = '{op: OP_EMIT,     cond: COND_OUT_FREE,    target: StWait};
      StRetry:   w = '{op: OP_NOP,      cond: COND_ALWAYS,      target: StEmit};
      default:   w = '{op: OP_NOP,      cond: COND_ALWAYS,      target: StWait};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

### rtl/dev_if.sv
`default_nettype none

interface dev_in_if import dev_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic signed [WordW-1:0] depth_sample;
  logic        [WordW-1:0] tick_stamp;

  modport source (output valid, depth_sample, tick_stamp, input ready);
  modport sink   (input valid, depth_sample, tick_stamp, output ready);
endinterface

interface dev_out_if import dev_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic signed [WordW-1:0] smoothed_depth;
  logic signed [WordW-1:0] smoothed_velocity;
  logic                    estimate_valid;
  logic                    sample_ignored;

  modport source (output valid, smoothed_depth, smoothed_velocity, estimate_valid,
                  sample_ignored, input ready);
  modport sink   (input valid, smoothed_depth, smoothed_velocity, estimate_valid,
                  sample_ignored, output ready);
endinterface

`default_nettype wire

### rtl/dev_cfg_regs.sv
`default_nettype none

module dev_cfg_regs import dev_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [PdataW-1:0] pwdata,
  output logic [PdataW-1:0] prdata,
  output logic              pready,
  output dev_cfg_t          cfg_o
);

  dev_cfg_t   cfg_q;
  logic [1:0] reg_idx;

  assign reg_idx = paddr[3:2];
  assign pready  = 1'b1;
  assign cfg_o   = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.depth_gain       <= GainOne;
      cfg_q.velocity_gain    <= GainOne;
      cfg_q.ticks_per_second <= TpsReset;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_idx)
        REG_DEPTH_GAIN:       cfg_q.depth_gain       <= pwdata[GainW-1:0];
        REG_VELOCITY_GAIN:    cfg_q.velocity_gain    <= pwdata[GainW-1:0];
        REG_TICKS_PER_SECOND: cfg_q.ticks_per_second <= pwdata[TpsW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_DEPTH_GAIN:       prdata = PdataW'(cfg_q.depth_gain);
      REG_VELOCITY_GAIN:    prdata = PdataW'(cfg_q.velocity_gain);
      REG_TICKS_PER_SECOND: prdata = PdataW'(cfg_q.ticks_per_second);
      default:              prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

### rtl/dev_sequencer.sv
`default_nettype none

module dev_sequencer import dev_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  dev_stat_t stat_i,
  output dev_op_e   op_o
);

  logic [PcW-1:0] pc_q, pc_d;
  dev_ctrl_t      ctrl;
  logic           taken;

  assign ctrl = dev_ucode(pc_q);
  assign op_o = ctrl.op;

  always_comb begin
    unique case (ctrl.cond)
      COND_NEVER:       taken = 1'b0;
      COND_ALWAYS:      taken = 1'b1;
      COND_NO_IN:       taken = !stat_i.in_valid;
      COND_NOT_STARTED: taken = !stat_i.started;
      COND_TICK_SAME:   taken = stat_i.tick_same;
      COND_DIV_MORE:    taken = stat_i.div_more;
      COND_VEL_NEW:     taken = !stat_i.vel_started;
      COND_OUT_FREE:    taken = stat_i.out_free;
      default:          taken = 1'b1;
    endcase
    pc_d = taken ? ctrl.target : pc_q + PcW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= StWait;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

`default_nettype wire

### rtl/dev_datapath.sv
`default_nettype none

module dev_datapath import dev_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  dev_op_e   op_i,
  input  dev_cfg_t  cfg_i,
  dev_in_if.sink    in_ch,
  dev_out_if.source out_ch,
  output dev_stat_t stat_o
);

  localparam logic [DivW-1:0] QPosLim = DivW'(WordMax);
  localparam logic [DivW-1:0] QNegLim = QPosLim + DivW'(1);

  logic signed [WordW-1:0] sample_q, fd_q, fv_q, old_q, raw_q;
  logic        [WordW-1:0] tick_q, last_q, dt_q, rem_q;
  logic                    started_q, vel_started_q, ign_q, neg_q;
  logic signed [DiffW-1:0] diff_q, diff_d, diff_a, diff_b;
  logic signed [ProdW-1:0] prod_q, prod_d, prod_mag;
  logic        [DivW-1:0]  quot_q;
  logic        [CntW-1:0]  cnt_q;
  logic        [TpsW-1:0]  mul_a;
  logic signed [WordW-1:0] smooth_base, smooth_res, raw_d;
  logic signed [AdjW-1:0]  adj;
  logic signed [SumW-1:0]  sum;
  logic        [WordW:0]   rem_sh, rem_sub;
  logic                    rem_ge, out_free;

  logic                    out_valid_q, out_est_q, out_ign_q;
  logic signed [WordW-1:0] out_depth_q, out_vel_q;

  assign in_ch.ready = (op_i == OP_LATCH);
  assign out_free    = !out_valid_q || out_ch.ready;

  assign out_ch.valid             = out_valid_q;
  assign out_ch.smoothed_depth    = out_depth_q;
  assign out_ch.smoothed_velocity = out_vel_q;
  assign out_ch.estimate_valid    = out_est_q;
  assign out_ch.sample_ignored    = out_ign_q;

  assign stat_o.in_valid    = in_ch.valid;
  assign stat_o.started     = started_q;
  assign stat_o.vel_started = vel_started_q;
  assign stat_o.tick_same   = (tick_q == last_q);
  assign stat_o.div_more    = (cnt_q != CntW'(DivW - 1));
  assign stat_o.out_free    = out_free;

  always_comb begin
    unique case (op_i)
      OP_MUL_D: mul_a = TpsW'(cfg_i.depth_gain);
      OP_MUL_V: mul_a = TpsW'(cfg_i.velocity_gain);
      default:  mul_a = cfg_i.ticks_per_second;
    endcase
    prod_d = ProdW'($signed({1'b0, mul_a})) * ProdW'(diff_q);

    unique case (op_i)
      OP_DZ: begin
        diff_a = DiffW'(fd_q);
        diff_b = DiffW'(old_q);
      end
      OP_DIFF_V: begin
        diff_a = DiffW'(raw_q);
        diff_b = DiffW'(fv_q);
      end
      default: begin
        diff_a = DiffW'(sample_q);
        diff_b = DiffW'(fd_q);
      end
    endcase
    diff_d = diff_a - diff_b;

    smooth_base = (op_i == OP_ADD_V) ? fv_q : fd_q;
    adj         = AdjW'(prod_q >>> FracBits);
    sum         = SumW'(smooth_base) + SumW'(adj);
    if (sum > SumW'(WordMax)) begin
      smooth_res = WordMax;
    end else if (sum < SumW'(WordMin)) begin
      smooth_res = WordMin;
    end else begin
      smooth_res = sum[WordW-1:0];
    end

    prod_mag = prod_q[ProdW-1] ? -prod_q : prod_q;
    rem_sh   = {rem_q, quot_q[DivW-1]};
    rem_ge   = (rem_sh >= {1'b0, dt_q});
    rem_sub  = rem_sh - {1'b0, dt_q};

    if (!neg_q) begin
      raw_d = (quot_q > QPosLim) ? WordMax : quot_q[WordW-1:0];
    end else begin
      raw_d = (quot_q > QNegLim) ? WordMin : -quot_q[WordW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q     <= 1'b0;
      vel_started_q <= 1'b0;
      fd_q          <= '0;
      fv_q          <= '0;
      last_q        <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (op_i == OP_EMIT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (op_i)
        OP_FIRST: begin
          fd_q          <= sample_q;
          fv_q          <= '0;
          last_q        <= tick_q;
          started_q     <= 1'b1;
          vel_started_q <= 1'b0;
        end
        OP_ADD_D: fd_q <= smooth_res;
        OP_FIRST_V: begin
          fv_q          <= raw_q;
          vel_started_q <= 1'b1;
          last_q        <= tick_q;
        end
        OP_ADD_V: begin
          fv_q   <= smooth_res;
          last_q <= tick_q;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (op_i)
      OP_LATCH: begin
        if (in_ch.valid) begin
          sample_q <= in_ch.depth_sample;
          tick_q   <= in_ch.tick_stamp;
        end
        ign_q <= 1'b0;
      end
      OP_DT:     dt_q  <= tick_q - last_q;
      OP_IGNORE: ign_q <= 1'b1;
      OP_DIFF_D, OP_DZ, OP_DIFF_V: diff_q <= diff_d;
      OP_MUL_D, OP_MUL_T, OP_MUL_V: prod_q <= prod_d;
      OP_ADD_D:  old_q <= fd_q;
      OP_DIV_INIT: begin
        neg_q  <= prod_q[ProdW-1];
        quot_q <= prod_mag[DivW-1:0];
        rem_q  <= '0;
        cnt_q  <= '0;
      end
      OP_DIV_STEP: begin
        rem_q  <= rem_ge ? rem_sub[WordW-1:0] : rem_sh[WordW-1:0];
        quot_q <= {quot_q[DivW-2:0], rem_ge};
        cnt_q  <= cnt_q + CntW'(1);
      end
      OP_QSAT:   raw_q <= raw_d;
      OP_EMIT: begin
        if (out_free) begin
          out_depth_q <= fd_q;
          out_vel_q   <= fv_q;
          out_est_q   <= started_q;
          out_ign_q   <= ign_q;
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

### rtl/depth_ema_velocity_estimator_core.sv
`default_nettype none

// Depth smoother and vertical speed estimator. Each transfer on in_ch gives exactly one
// transfer on out_ch. The first sample after reset loads the depth filter and reports zero
// velocity; a sample with the same tick stamp as the last used one changes nothing and is
// flagged as ignored; any other sample is smoothed with depth_gain, its depth change is scaled
// by ticks_per_second and divided by the wrapped tick difference, and the result feeds the
// velocity filter. A small microcode program steps one shared multiplier, adder and
// divider; the restoring divider gives one quotient bit per cycle. A sample is taken in
// only after the result of the one before it has been placed in the output register, and
// the next sample can be taken in the same cycle as that result appears. A finished
// result waits in the output register while the next sample is taken in.

module depth_ema_velocity_estimator_core import dev_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  dev_in_if.sink            in_ch,
  dev_out_if.source         out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [PdataW-1:0] pwdata,
  output logic [PdataW-1:0] prdata,
  output logic              pready
);

  dev_cfg_t  cfg;
  dev_stat_t stat;
  dev_op_e   op;

  dev_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  dev_sequencer u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .op_o   (op)
  );

  dev_datapath u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .op_i   (op),
    .cfg_i  (cfg),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .stat_o (stat)
  );

endmodule

`default_nettype wire

### rtl/dev_checker.sv
`default_nettype none

module dev_checker import dev_pkg::*; (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic signed [WordW-1:0] smoothed_depth,
  input logic signed [WordW-1:0] smoothed_velocity,
  input logic                    estimate_valid,
  input logic                    sample_ignored
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid)
    else $error("Result dropped before its transfer.");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> $stable(smoothed_depth) && $stable(smoothed_velocity)
                                && $stable(sample_ignored))
    else $error("Result changed while stalled.");

  a_est_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> estimate_valid)
    else $error("Result shown without a valid estimate.");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !in_ready)
    else $error("Second sample taken while one is in work.");

endmodule

bind depth_ema_velocity_estimator_core dev_checker u_chk (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid          (in_ch.valid),
  .in_ready          (in_ch.ready),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .smoothed_depth    (out_ch.smoothed_depth),
  .smoothed_velocity (out_ch.smoothed_velocity),
  .estimate_valid    (out_ch.estimate_valid),
  .sample_ignored    (out_ch.sample_ignored)
);

`default_nettype wire
